[rtl/core/cubic_spline_chord_step_search_unit_assert.svh]
// Assertion macros for the chord step search unit.
`ifndef CUBIC_SPLINE_CHORD_STEP_SEARCH_UNIT_ASSERT_SVH
`define CUBIC_SPLINE_CHORD_STEP_SEARCH_UNIT_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define CSS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Check an implication in the following cycle.
`define CSS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

[rtl/core/cscs_pkg.sv]
// Shared types and constants of the chord step search unit.
package cscs_pkg;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 63;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUBIC  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SQUARE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINEAR = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP   = 3'd4;
    localparam int STOP_BITS = 16;
    localparam int STEP_BITS = 20;
    localparam int SQ_BITS   = 64;

    // Square root unit handshake.
    typedef struct packed {
        logic start;
        logic [SQ_BITS-1:0] value;
    } sqrt_req_t;
    typedef struct packed {
        logic done;
        logic [SQ_BITS/2-1:0] root;
    } sqrt_rsp_t;
endpackage

[rtl/core/cscs_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
module cscs_sqrt (
    input  logic clk,
    input  logic rst_n,
    input  cscs_pkg::sqrt_req_t req,
    output cscs_pkg::sqrt_rsp_t rsp
);
    import cscs_pkg::*;

    localparam int RB = SQ_BITS / 2;

    logic [SQ_BITS-1:0] rem_reg, rem_next;
    logic [RB-1:0] root_reg, root_next;
    logic [SQ_BITS-1:0] val_reg, val_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [SQ_BITS+1:0] trial;
    logic [SQ_BITS+1:0] rem_sh;

    // Restoring square root: shift in two bits, try subtracting 4*root+1.
    always_comb
    begin
        rem_next = rem_reg;
        root_next = root_reg;
        val_next = val_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg, val_reg[SQ_BITS-1 -: 2]};
        trial = (SQ_BITS+2)'({root_reg, 2'b01});
        if (req.start)
        begin
            rem_next = '0;
            root_next = '0;
            val_next = req.value;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[SQ_BITS-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = SQ_BITS'(rem_sh - trial);
                root_next = {root_reg[RB-2:0], 1'b1};
            end
            else
            begin
                rem_next = SQ_BITS'(rem_sh);
                root_next = {root_reg[RB-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(RB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        val_reg <= val_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

[rtl/core/cubic_spline_chord_step_search_unit.sv]
// Top level of the chord step search unit.
// One item at a time: in_ready is low from the accepting edge until the result has left.
// Each curve evaluation runs the three axes one after another through one shared
// multiplier: per axis a coefficient load, three Horner product and add pairs, a squaring
// and an accumulate, then one decision step per point. The search makes one evaluation
// at t = 1 and then up to PARAM_BITS bisection rounds, fewer with a wider stop value
// in REG_STOP or a later previous parameter. A reached end takes one evaluation and
// then the bit-serial square root. A result stalled by out_ready adds its wait.
module cubic_spline_chord_step_search_unit #(
    parameter int COORD_BITS = 21,
    parameter int PARAM_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [cscs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cscs_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [COORD_BITS-1:0] prev_x,
    input  logic signed [COORD_BITS-1:0] prev_y,
    input  logic signed [COORD_BITS-1:0] prev_z,
    input  logic [PARAM_BITS:0] prev_param,
    input  logic [cscs_pkg::STEP_BITS-1:0] step_length,
    output logic out_valid,
    input  logic out_ready,
    output logic [PARAM_BITS:0] next_param,
    output logic [cscs_pkg::STEP_BITS-1:0] step_taken,
    output logic end_reached
);
    import cscs_pkg::*;

    localparam int TB = PARAM_BITS + 1;
    localparam int AW = COORD_BITS + 3;            // Horner value and its axis difference
    localparam int MW = AW + TB;                   // Horner product width
    localparam int OW = (AW > 33) ? AW : 33;       // shared multiplier operand width
    localparam int WW = (TB + 1 > STOP_BITS) ? TB + 1 : STOP_BITS;
    localparam logic [TB-1:0] ONE = TB'(1) << PARAM_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOADA = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ADD   = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_WAITR = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [CFG_DATA_BITS-1:0] cub_reg, sqr_reg, lin_reg, off_reg;
    logic [STOP_BITS-1:0] stop_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cub_reg <= '0;
            sqr_reg <= '0;
            lin_reg <= '0;
            off_reg <= '0;
            stop_reg <= STOP_BITS'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CUBIC:  cub_reg <= cfg_data;
                REG_SQUARE: sqr_reg <= cfg_data;
                REG_LINEAR: lin_reg <= cfg_data;
                REG_OFFSET: off_reg <= cfg_data;
                REG_STOP:   stop_reg <= cfg_data[STOP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Coefficient field select, zero beyond bit 63.
    function automatic logic signed [AW-1:0] field(input logic [CFG_DATA_BITS-1:0] r,
                                                   input logic [1:0] ax);
        logic [63:0] w;
        logic [COORD_BITS-1:0] f;
        int sh;
        w = {1'b0, r};
        sh = int'(ax) * COORD_BITS;
        f = '0;
        if (sh < 64)
            f = COORD_BITS'(w >> sh);
        return AW'(signed'(f));
    endfunction

    logic [3:0] st_reg, st_next;
    logic [1:0] ax_reg, ax_next, hs_reg, hs_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [2*STEP_BITS-1:0] want_reg;
    logic [TB-1:0] lo_reg, lo_next, up_reg, up_next, t_reg, t_next;
    logic [WW-1:0] wid_reg;
    logic signed [AW-1:0] a_reg, a_next;
    logic signed [MW-1:0] p_reg, p_next;
    logic [SQ_BITS-1:0] sq_reg, sq_next, sum_reg, sum_next;
    logic first_reg, first_next;
    logic [TB-1:0] onp_reg, onp_next;
    logic [STEP_BITS-1:0] ost_reg, ost_next;
    logic oend_reg, oend_next;
    sqrt_req_t sreq;
    sqrt_rsp_t srsp;

    logic signed [AW-1:0] coef_add, prev_ax, diff;
    logic signed [MW-1:0] rnd;
    logic signed [AW-1:0] rq;
    logic [SQ_BITS-1:0] mag;
    logic [SQ_BITS:0] sum_w;
    logic [TB:0] span;
    logic signed [OW-1:0] mul_a, mul_b;
    logic signed [2*OW-1:0] mul_p;

    cscs_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

    always_comb
    begin
        case (hs_reg)
            2'd0: coef_add = field(sqr_reg, ax_reg);
            2'd1: coef_add = field(lin_reg, ax_reg);
            default: coef_add = field(off_reg, ax_reg);
        endcase
        case (ax_reg)
            2'd0: prev_ax = AW'(px_reg);
            2'd1: prev_ax = AW'(py_reg);
            default: prev_ax = AW'(pz_reg);
        endcase
    end

    // Datapath and sequencer.
    always_comb
    begin
        st_next = st_reg;
        ax_next = ax_reg;
        hs_next = hs_reg;
        lo_next = lo_reg;
        up_next = up_reg;
        t_next = t_reg;
        a_next = a_reg;
        p_next = p_reg;
        sq_next = sq_reg;
        sum_next = sum_reg;
        first_next = first_reg;
        onp_next = onp_reg;
        ost_next = ost_reg;
        oend_next = oend_reg;
        sreq.start = 1'b0;
        sreq.value = sum_reg;
        rnd = p_reg + (MW'(1) <<< (PARAM_BITS - 1));
        rq = AW'(rnd >>> PARAM_BITS);
        diff = a_reg - prev_ax;
        mag = diff[AW-1] ? SQ_BITS'(-diff) : SQ_BITS'(diff);
        sum_w = {1'b0, sum_reg} + {1'b0, sq_reg};
        span = {1'b0, up_reg} - {1'b0, lo_reg};
        // Shared multiplier: squares the axis distance, else a Horner product.
        if (st_reg == S_SQ)
        begin
            mul_a = OW'({1'b0, mag[31:0]});
            mul_b = OW'({1'b0, mag[31:0]});
        end
        else
        begin
            mul_a = OW'(a_reg);
            mul_b = OW'({1'b0, t_reg});
        end
        mul_p = mul_a * mul_b;
        case (st_reg)
            S_LOADA:
            begin
                a_next = field(cub_reg, ax_reg);
                hs_next = 2'd0;
                st_next = S_MUL;
            end
            S_MUL:
            begin
                p_next = MW'(mul_p);
                st_next = S_ADD;
            end
            S_ADD:
            begin
                a_next = rq + coef_add;
                if (hs_reg == 2'd2)
                    st_next = S_SQ;
                else
                begin
                    hs_next = hs_reg + 2'd1;
                    st_next = S_MUL;
                end
            end
            S_SQ:
            begin
                if (mag >= 64'h1_0000_0000)
                    sq_next = '1;
                else
                    sq_next = mul_p[SQ_BITS-1:0];
                st_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_w[SQ_BITS] ? '1 : sum_w[SQ_BITS-1:0];
                if (ax_reg == 2'd2)
                    st_next = S_DEC;
                else
                begin
                    ax_next = ax_reg + 2'd1;
                    st_next = S_LOADA;
                end
            end
            S_DEC:
            begin
                ax_next = 2'd0;
                st_next = S_LOADA;
                sum_next = '0;
                if (first_reg && sum_reg <= SQ_BITS'(want_reg))
                begin
                    onp_next = ONE;
                    oend_next = 1'b1;
                    sreq.start = 1'b1;
                    st_next = S_SQRT;
                end
                else if (WW'(span) <= wid_reg)
                begin
                    onp_next = t_reg;
                    ost_next = step_reg;
                    oend_next = 1'b0;
                    st_next = S_OUT;
                end
                else
                begin
                    first_next = 1'b0;
                    if (sum_reg > SQ_BITS'(want_reg))
                    begin
                        up_next = t_reg;
                        t_next = TB'(({1'b0, lo_reg} + {1'b0, t_reg}) >> 1);
                    end
                    else
                    begin
                        lo_next = t_reg;
                        t_next = TB'(({1'b0, t_reg} + {1'b0, up_reg}) >> 1);
                    end
                end
            end
            S_SQRT:
                st_next = S_WAITR;
            S_WAITR:
                if (srsp.done)
                begin
                    ost_next = srsp.root[STEP_BITS-1:0];
                    st_next = S_OUT;
                end
            S_OUT:
                if (out_ready)
                    st_next = S_IDLE;
            default:
            begin
                if (in_valid)
                begin
                    lo_next = (prev_param > ONE) ? ONE : prev_param;
                    up_next = ONE;
                    t_next = ONE;
                    ax_next = 2'd0;
                    sum_next = '0;
                    first_next = 1'b1;
                    st_next = S_LOADA;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    // Payload capture and working registers.
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && in_valid)
        begin
            px_reg <= prev_x;
            py_reg <= prev_y;
            pz_reg <= prev_z;
            step_reg <= step_length;
            want_reg <= step_length * step_length;
            wid_reg <= (stop_reg == '0) ? WW'(1) : WW'(stop_reg);
        end
        ax_reg <= ax_next;
        hs_reg <= hs_next;
        lo_reg <= lo_next;
        up_reg <= up_next;
        t_reg <= t_next;
        a_reg <= a_next;
        p_reg <= p_next;
        sq_reg <= sq_next;
        sum_reg <= sum_next;
        first_reg <= first_next;
        onp_reg <= onp_next;
        ost_reg <= ost_next;
        oend_reg <= oend_next;
    end

    assign in_ready = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign next_param = onp_reg;
    assign step_taken = ost_reg;
    assign end_reached = oend_reg;
endmodule

[rtl/core/cscs_checker.sv]
// Port-level checker for the chord step search unit, with its bind.
module cscs_checker #(
    parameter int PARAM_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [PARAM_BITS:0] next_param,
    input logic end_reached
);
`include "cubic_spline_chord_step_search_unit_assert.svh"
    // One item in flight: never ready while a result is shown.
    `CSS_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
    // Accepting an item drops ready next cycle.
    `CSS_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
    // A reached end always reports parameter one.
    `CSS_ASSERT_IMP(a_end, clk, rst_n, out_valid && end_reached,
                    next_param == ((PARAM_BITS+1)'(1) << PARAM_BITS))
    // Result holds while stalled.
    `CSS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(next_param))
endmodule

bind cubic_spline_chord_step_search_unit cscs_checker #(.PARAM_BITS(PARAM_BITS)) u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .next_param(next_param),
    .end_reached(end_reached)
);
